>>> rtl/core/pmq_pkg.sv
// Shared field widths and request/status codes of the packet match queue.
package pmq_pkg;

  // Field widths fixed by the packet header format
  localparam int CMD_W     = 2;
  localparam int TYPE_W    = 3;
  localparam int SRC_W     = 64;
  localparam int BYTES_W   = 12;
  localparam int TAG_IN_W  = 16;
  localparam int STATUS_W  = 3;
  localparam int WRITERS_W = 16;
  localparam int FILL_W    = 5;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_PKT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MATCH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITER = 2'd2;

  // Packet types
  localparam logic [TYPE_W-1:0] TYPE_CONNECT = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_ACCEPT  = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_DISCON  = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_MSG     = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DISC   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_WRITER = 3'd5;

  localparam logic [WRITERS_W-1:0] WRITER_MAX = 16'hFFFF;

endpackage

>>> rtl/core/pmq_entry_ram.sv
// Header entry memory: one write port, one registered read port.
module pmq_entry_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 95
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/packet_match_queue.sv
// Top level: ordered packet header queue with matched removal and writer count.
// Sequence: store, drop, disconnect, writer and unknown requests go from idle to the finish
//   step and then to the output register; a match first scans oldest first and closes up the queue.
// Flow: one request in flight; the input is not ready again until the result is loaded into the
//   output register, so a result not yet taken holds the input off.
// Reset: rst_n (synchronous) clears fill count, writer count and control state only.
module packet_match_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: src_id[63:0], payload_bytes[75:64], payload_tag[91:76], zero pad
  input  logic [95:0]  in_tdata,
  // in_tuser: cmd[1:0], pkt_type[4:2]
  input  logic [4:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: out_src[63:0], out_bytes[75:64], out_tag[91:76],
  //            writers_active[107:92], queue_fill[112:108], zero pad
  output logic [119:0] out_tdata,
  // out_tuser: status[2:0]
  output logic [2:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready
);

  localparam int AW     = $clog2(QUEUE_DEPTH);
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int TW     = (TAG_BITS < pmq_pkg::TAG_IN_W) ? TAG_BITS : pmq_pkg::TAG_IN_W;
  localparam int SRC_LO = pmq_pkg::TYPE_W;
  localparam int BYT_LO = SRC_LO + pmq_pkg::SRC_W;
  localparam int TAG_LO = BYT_LO + pmq_pkg::BYTES_W;
  localparam int DATA_W = TAG_LO + TW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FIN
  } state_t;

  state_t                        state_r;
  logic [CW-1:0]                 fill_r;
  logic [pmq_pkg::WRITERS_W-1:0] writer_r;
  logic [AW-1:0]                 idx_r;

  // Latched request
  logic [pmq_pkg::TYPE_W-1:0]    req_type_r;
  logic [pmq_pkg::SRC_W-1:0]     req_src_r;

  // Pending result
  logic [pmq_pkg::STATUS_W-1:0]  res_status_r;
  logic [pmq_pkg::SRC_W-1:0]     res_src_r;
  logic [pmq_pkg::BYTES_W-1:0]   res_bytes_r;
  logic [TW-1:0]                 res_tag_r;

  // Output register
  logic                          out_valid_r;
  logic [pmq_pkg::STATUS_W-1:0]  out_status_r;
  logic [pmq_pkg::SRC_W-1:0]     out_src_r;
  logic [pmq_pkg::BYTES_W-1:0]   out_bytes_r;
  logic [pmq_pkg::TAG_IN_W-1:0]  out_tag_r;
  logic [pmq_pkg::WRITERS_W-1:0] out_writers_r;
  logic [pmq_pkg::FILL_W-1:0]    out_fill_r;

  // Input fields
  logic [pmq_pkg::CMD_W-1:0]     in_cmd;
  logic [pmq_pkg::TYPE_W-1:0]    in_type;
  logic [pmq_pkg::SRC_W-1:0]     in_src;
  logic [pmq_pkg::BYTES_W-1:0]   in_bytes;
  logic [pmq_pkg::TAG_IN_W-1:0]  in_tag;

  // Entry memory port
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [DATA_W-1:0]             ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [DATA_W-1:0]             ram_rdata;

  logic                          in_acc;
  logic                          q_full;
  logic                          store_ok;
  logic [CW-1:0]                 idx_inc;
  logic                          last_entry;
  logic                          hit;
  logic                          out_free;
  logic [31:0]                   fill_ext;
  logic [pmq_pkg::TYPE_W-1:0]    ent_type;
  logic [pmq_pkg::SRC_W-1:0]     ent_src;
  logic [pmq_pkg::BYTES_W-1:0]   ent_bytes;
  logic [TW-1:0]                 ent_tag;

  assign in_cmd   = in_tuser[1:0];
  assign in_type  = in_tuser[4:2];
  assign in_src   = in_tdata[63:0];
  assign in_bytes = in_tdata[75:64];
  assign in_tag   = in_tdata[91:76];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign q_full    = (fill_r == CW'(QUEUE_DEPTH));
  assign store_ok  = (in_cmd == pmq_pkg::CMD_PKT) && (in_type != pmq_pkg::TYPE_DISCON)
                     && !q_full;

  // Entry fields of the word read in the previous cycle
  assign ent_type  = ram_rdata[SRC_LO-1:0];
  assign ent_src   = ram_rdata[BYT_LO-1:SRC_LO];
  assign ent_bytes = ram_rdata[TAG_LO-1:BYT_LO];
  assign ent_tag   = ram_rdata[DATA_W-1:TAG_LO];

  assign idx_inc    = CW'(idx_r) + CW'(1);
  assign last_entry = (idx_inc == fill_r);
  assign hit        = (ent_type == req_type_r) &&
                      ((req_type_r == pmq_pkg::TYPE_CONNECT) || (ent_src == req_src_r));
  assign out_free   = !out_valid_r || out_tready;
  assign fill_ext   = 32'(fill_r);

  // Drive the memory port: append in idle, move one entry down while closing up
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_r[AW-1:0];
    ram_wdata = {in_tag[TW-1:0], in_bytes, in_src, in_type};
    ram_raddr = (state_r == ST_IDLE) ? '0 : idx_inc[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        ram_we = in_acc && store_ok;
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - AW'(1);
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pmq_entry_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      writer_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load on finish, drop the output once taken
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            req_type_r  <= in_type;
            req_src_r   <= in_src;
            res_src_r   <= '0;
            res_bytes_r <= '0;
            res_tag_r   <= '0;
            idx_r       <= '0;
            state_r     <= (in_cmd == pmq_pkg::CMD_MATCH && fill_r != '0) ? ST_SCAN : ST_FIN;
            case (in_cmd)
              pmq_pkg::CMD_PKT: begin
                if (in_type == pmq_pkg::TYPE_DISCON) begin
                  if (writer_r != '0) begin
                    writer_r <= writer_r - 16'd1;
                  end
                  res_status_r <= pmq_pkg::ST_DISC;
                end else if (q_full) begin
                  res_status_r <= pmq_pkg::ST_FULL;
                end else begin
                  fill_r       <= fill_r + CW'(1);
                  res_status_r <= pmq_pkg::ST_STORED;
                end
              end
              pmq_pkg::CMD_WRITER: begin
                if (writer_r != pmq_pkg::WRITER_MAX) begin
                  writer_r <= writer_r + 16'd1;
                end
                res_status_r <= pmq_pkg::ST_WRITER;
              end
              default: begin
                res_status_r <= pmq_pkg::ST_MISS;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // compare one entry per cycle, oldest first
          idx_r <= idx_inc[AW-1:0];
          if (hit) begin
            res_status_r <= pmq_pkg::ST_FOUND;
            res_src_r    <= ent_src;
            res_bytes_r  <= ent_bytes;
            res_tag_r    <= ent_tag;
            fill_r       <= fill_r - CW'(1);
            state_r      <= last_entry ? ST_FIN : ST_SHIFT;
          end else if (last_entry) begin
            state_r <= ST_FIN;
          end
        end
        ST_SHIFT: begin
          // advance; fill_r already holds the reduced count
          idx_r <= idx_inc[AW-1:0];
          if (CW'(idx_r) == fill_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_status_r  <= res_status_r;
            out_src_r     <= res_src_r;
            out_bytes_r   <= res_bytes_r;
            out_tag_r     <= 16'(res_tag_r);
            out_writers_r <= writer_r;
            out_fill_r    <= fill_ext[4:0];
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'b0, out_fill_r, out_writers_r, out_tag_r, out_bytes_r, out_src_r};

`ifndef SYNTHESIS
  // The fill count never passes the queue depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(QUEUE_DEPTH))
    else $error("fill count exceeds queue depth");

  // Closing up never writes below slot zero
  a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (idx_r != '0))
    else $error("shift with zero source index");

  // A result is loaded only when the sequencer finishes a request
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("output loaded outside finish step");

  // An accepted store grows the queue by one
  a_store_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && store_ok) |=> (fill_r == $past(fill_r) + CW'(1)))
    else $error("store did not advance fill count");

  // A hit removes exactly one entry
  a_hit_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && hit) |=> (fill_r == $past(fill_r) - CW'(1)))
    else $error("match did not remove one entry");
`endif

endmodule
